// ===== sv/bgpc_pkg.sv =====
`default_nettype none

package bgpc_pkg;

    // Widths fixed by the word format.
    localparam int unsigned GATE_W  = 4;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 16;

    // Width used when comparing a gate number against the active limit;
    // wide enough for any gate count the block supports.
    localparam int unsigned LIMIT_W = 6;

    // Per-sample outcome of the gate state update.
    typedef struct packed {
        logic              passage_in;
        logic              passage_out;
        logic [TIME_W-1:0] transit_us;
    } gate_res_t;

endpackage

`default_nettype wire

// ===== sv/bidirectional_gate_passage_counter.sv =====
`default_nettype none

// Bidirectional two-beam gate passage counter.
//
// The input channel (in_valid / in_stall) carries one word per sensor sample:
// the gate number, both beam bits and a microsecond timestamp. A word is taken
// at a rising edge where in_valid is high and in_stall is low. Every accepted
// word produces exactly one result word on the output channel (out_valid /
// out_stall) holding the passage flags, the transit time, both running totals
// and the ignored flag.
//
// The sample is captured in an input register, and the per-gate update then runs
// into the result register. Throughput is one word per cycle while out_stall is
// low, since the per-gate phase and start-time flops are written as each result
// is registered, so samples of the same gate may follow back to back.
//
// When the receiver stalls, the result word holds and the pipeline freezes; in_stall rises
// only when the input register is full and cannot move on. Reset clears all gates to idle,
// both totals to zero, and active_gates to 2. The user must write active_gates through
// cfg_we / cfg_data only while the block is idle; the block itself does not enforce it.
module bidirectional_gate_passage_counter #(
    parameter int unsigned GATES = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_we,
    input  wire logic [3:0]                    cfg_data,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [bgpc_pkg::GATE_W-1:0]   gate,
    input  wire logic                          sensor_a,
    input  wire logic                          sensor_b,
    input  wire logic [bgpc_pkg::TIME_W-1:0]   timestamp_us,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               passage_in,
    output logic                               passage_out,
    output logic [bgpc_pkg::TIME_W-1:0]        transit_us,
    output logic [bgpc_pkg::COUNT_W-1:0]       in_total,
    output logic [bgpc_pkg::COUNT_W-1:0]       out_total,
    output logic                               ignored
);

    localparam int unsigned IDX_W = (GATES > 1) ? $clog2(GATES) : 1;
    localparam int unsigned LW    = bgpc_pkg::LIMIT_W;

    // Configuration register.
    logic [3:0]                        active_reg;

    // Input register.
    logic                              s1_valid_reg;
    logic [bgpc_pkg::GATE_W-1:0]       gate_reg;
    logic                              a_reg;
    logic                              b_reg;
    logic [bgpc_pkg::TIME_W-1:0]       ts_reg;

    // Running totals.
    logic [bgpc_pkg::COUNT_W-1:0]      in_count_reg;
    logic [bgpc_pkg::COUNT_W-1:0]      out_count_reg;
    logic [bgpc_pkg::COUNT_W-1:0]      in_count_next;
    logic [bgpc_pkg::COUNT_W-1:0]      out_count_next;

    // Result register.
    logic                              out_valid_reg;
    logic                              pin_reg;
    logic                              pout_reg;
    logic [bgpc_pkg::TIME_W-1:0]       transit_reg;
    logic [bgpc_pkg::COUNT_W-1:0]      in_total_reg;
    logic [bgpc_pkg::COUNT_W-1:0]      out_total_reg;
    logic                              ignored_reg;

    logic                              advance;
    logic                              fire;
    logic                              in_accept;
    logic [LW-1:0]                     limit;
    logic [LW-1:0]                     gate_wide;
    logic                              ign;
    logic [IDX_W-1:0]                  idx;
    bgpc_pkg::gate_res_t               gres;
    logic                              pin;
    logic                              pout;

    // The result stage moves whenever its register is empty or being taken.
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // Active limit, clipped to the number of gates that exist.
    assign limit     = (LW'(active_reg) > LW'(GATES)) ? LW'(GATES) : LW'(active_reg);
    assign gate_wide = LW'(gate_reg);
    assign ign       = !(gate_wide < limit);
    assign idx       = gate_wide[IDX_W-1:0];

    bgpc_gate_state #(
        .GATES (GATES)
    ) u_gate_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .upd          (fire && !ign),
        .idx          (idx),
        .sensor_a     (a_reg),
        .sensor_b     (b_reg),
        .timestamp_us (ts_reg),
        .res          (gres)
    );

    assign pin  = gres.passage_in && !ign;
    assign pout = gres.passage_out && !ign;

    assign in_count_next  = in_count_reg + bgpc_pkg::COUNT_W'(pin);
    assign out_count_next = out_count_reg + bgpc_pkg::COUNT_W'(pout);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 4'd2;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_count_reg  <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_data;
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (fire)
            begin
                in_count_reg  <= in_count_next;
                out_count_reg <= out_count_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            gate_reg <= gate;
            a_reg    <= sensor_a;
            b_reg    <= sensor_b;
            ts_reg   <= timestamp_us;
        end
        if (fire)
        begin
            pin_reg       <= pin;
            pout_reg      <= pout;
            transit_reg   <= ign ? '0 : gres.transit_us;
            in_total_reg  <= in_count_next;
            out_total_reg <= out_count_next;
            ignored_reg   <= ign;
        end
    end

    assign out_valid   = out_valid_reg;
    assign passage_in  = pin_reg;
    assign passage_out = pout_reg;
    assign transit_us  = transit_reg;
    assign in_total    = in_total_reg;
    assign out_total   = out_total_reg;
    assign ignored     = ignored_reg;

    // A sample can never complete passages in both directions.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(passage_in && passage_out))
        else $error("both passage flags set");

    // An ignored gate never reports a passage or a transit time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ignored) |-> (!passage_in && !passage_out && transit_us == '0))
        else $error("ignored sample reported a passage");

    // The inward total moves only with a reported inward passage.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (in_count_reg == $past(in_count_reg) + bgpc_pkg::COUNT_W'(passage_in)))
        else $error("inward total out of step with passage flag");

    // Without a passage, no transit time is shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !passage_in && !passage_out) |-> (transit_us == '0))
        else $error("transit time without passage");

endmodule

`default_nettype wire

// ===== sv/bgpc_gate_state.sv =====
`default_nettype none

module bgpc_gate_state #(
    parameter int unsigned GATES = 12
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       upd,
    input  wire logic [((GATES > 1) ? $clog2(GATES) : 1)-1:0] idx,
    input  wire logic                                       sensor_a,
    input  wire logic                                       sensor_b,
    input  wire logic [bgpc_pkg::TIME_W-1:0]                timestamp_us,
    output bgpc_pkg::gate_res_t                             res
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_IN   = 2'd1;
    localparam logic [1:0] PH_OUT  = 2'd2;
    localparam logic [1:0] PH_HOLD = 2'd3;

    logic [1:0]                      phase_reg [GATES];
    logic [bgpc_pkg::TIME_W-1:0]     start_reg [GATES];

    logic [1:0]                      cur_phase;
    logic [bgpc_pkg::TIME_W-1:0]     cur_start;
    logic [1:0]                      phase_next;
    logic                            start_we;

    assign cur_phase = phase_reg[idx];
    assign cur_start = start_reg[idx];

    always_comb
    begin
        phase_next = cur_phase;
        start_we   = 1'b0;
        res        = '0;
        unique case (cur_phase)
            PH_IDLE:
            begin
                if (sensor_a && !sensor_b)
                begin
                    phase_next = PH_IN;
                    start_we   = 1'b1;
                end
                else if (sensor_b && !sensor_a)
                begin
                    phase_next = PH_OUT;
                    start_we   = 1'b1;
                end
            end
            PH_IN, PH_OUT:
            begin
                if (sensor_a && sensor_b)
                begin
                    // Both beams cut: the passage is complete in the armed direction.
                    res.transit_us  = timestamp_us - cur_start;
                    res.passage_in  = (cur_phase == PH_IN);
                    res.passage_out = (cur_phase == PH_OUT);
                    phase_next      = PH_HOLD;
                end
                else if (!sensor_a && !sensor_b)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_HOLD:
            begin
                if (!sensor_a && !sensor_b)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GATES; i++)
            begin
                phase_reg[i] <= PH_IDLE;
            end
        end
        else if (upd)
        begin
            phase_reg[idx] <= phase_next;
        end
    end

    // Start times need no reset: they are only read after being written.
    always_ff @(posedge clk)
    begin
        if (upd && start_we)
        begin
            start_reg[idx] <= timestamp_us;
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_bidirectional_gate_passage_counter.sv =====
`timescale 1ns / 100ps

// Testbench for the two-beam gate passage counter.
//
// An initial block builds the sensor samples phase by phase and pushes them onto
// sample_q. A clocked driver takes words from that queue in bursts of random
// length, with random gaps between the bursts. Each time a word is accepted, the
// driver runs it through a local copy of the per-gate state machine. The result
// that this copy predicts is pushed onto expected_passages. A clocked monitor
// drives out_stall after its own pattern. It compares each accepted result word,
// field by field, with the oldest prediction.
module tb_bidirectional_gate_passage_counter;

    localparam int unsigned GATES          = 12;
    localparam int unsigned CLK_PERIOD     = 4;
    localparam int unsigned RESET_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned ITEMS_PER_RUN  = 150;
    localparam int unsigned MAX_REPORTS    = 10;

    // Per-gate phase of the passage state machine.
    typedef enum logic [1:0] {
        GP_IDLE = 2'd0,
        GP_IN   = 2'd1,
        GP_OUT  = 2'd2,
        GP_HOLD = 2'd3
    } gate_phase_t;

    // How the receiver stalls, apart from the one long hold.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PATTERN,
        STALL_HEAVY
    } stall_mode_t;

    typedef struct packed {
        logic [bgpc_pkg::GATE_W-1:0] gate;
        logic                        a;
        logic                        b;
        logic [bgpc_pkg::TIME_W-1:0] ts;
    } sensor_word_t;

    typedef struct packed {
        logic                         passage_in;
        logic                         passage_out;
        logic [bgpc_pkg::TIME_W-1:0]  transit_us;
        logic [bgpc_pkg::COUNT_W-1:0] in_total;
        logic [bgpc_pkg::COUNT_W-1:0] out_total;
        logic                         ignored;
    } passage_result_t;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Block ports. Every input has a known value from time zero.
    logic                         cfg_we       = 1'b0;
    logic [3:0]                   cfg_data     = '0;
    logic                         in_valid     = 1'b0;
    logic                         in_stall;
    logic [bgpc_pkg::GATE_W-1:0]  gate         = '0;
    logic                         sensor_a     = 1'b0;
    logic                         sensor_b     = 1'b0;
    logic [bgpc_pkg::TIME_W-1:0]  timestamp_us = '0;
    logic                         out_valid;
    logic                         out_stall    = 1'b0;
    logic                         passage_in;
    logic                         passage_out;
    logic [bgpc_pkg::TIME_W-1:0]  transit_us;
    logic [bgpc_pkg::COUNT_W-1:0] in_total;
    logic [bgpc_pkg::COUNT_W-1:0] out_total;
    logic                         ignored;

    bidirectional_gate_passage_counter #(
        .GATES(GATES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .gate         (gate),
        .sensor_a     (sensor_a),
        .sensor_b     (sensor_b),
        .timestamp_us (timestamp_us),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .passage_in   (passage_in),
        .passage_out  (passage_out),
        .transit_us   (transit_us),
        .in_total     (in_total),
        .out_total    (out_total),
        .ignored      (ignored)
    );

    // Pending sensor words and predicted result words.
    sensor_word_t    sample_q[$];
    passage_result_t expected_passages[$];

    // Local copy of the block state; set_active_gates sets active_gates, the driver the rest.
    gate_phase_t                  phase_copy[GATES];
    logic [bgpc_pkg::TIME_W-1:0]  start_copy[GATES];
    logic [bgpc_pkg::COUNT_W-1:0] in_tally  = '0;
    logic [bgpc_pkg::COUNT_W-1:0] out_tally = '0;
    logic [3:0]                   active_gates = 4'd2;

    // Traffic shaping knobs, which the initial block sets for each phase.
    int unsigned gap_max    = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int unsigned hold_seq   = 0;

    // Per-gate stimulus script: the stage of the current passage, its direction
    // and the running timestamp of the gate.
    int unsigned                 gen_stage[16];
    logic                        gen_inward[16];
    logic [bgpc_pkg::TIME_W-1:0] gen_time[16];

    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;

    initial
    begin
        for (int i = 0; i < GATES; i++)
        begin
            phase_copy[i] = GP_IDLE;
            start_copy[i] = '0;
        end
    end

    // Works out the result word for one accepted sample and advances the
    // local gate state in the same way as the block.
    function automatic passage_result_t predict_passage(input sensor_word_t w);
        passage_result_t r;
        int unsigned     lim;
        r   = '0;
        lim = (active_gates > GATES) ? GATES : active_gates;
        if (w.gate >= lim)
        begin
            r.ignored = 1'b1;
        end
        else
        begin
            unique case (phase_copy[w.gate])
                GP_IDLE:
                begin
                    if (w.a && !w.b)
                    begin
                        phase_copy[w.gate] = GP_IN;
                        start_copy[w.gate] = w.ts;
                    end
                    else if (w.b && !w.a)
                    begin
                        phase_copy[w.gate] = GP_OUT;
                        start_copy[w.gate] = w.ts;
                    end
                end
                GP_IN, GP_OUT:
                begin
                    if (w.a && w.b)
                    begin
                        // Transit time wraps with the free-running timestamp.
                        r.transit_us = w.ts - start_copy[w.gate];
                        if (phase_copy[w.gate] == GP_IN)
                        begin
                            r.passage_in = 1'b1;
                            in_tally     = in_tally + 1'b1;
                        end
                        else
                        begin
                            r.passage_out = 1'b1;
                            out_tally     = out_tally + 1'b1;
                        end
                        phase_copy[w.gate] = GP_HOLD;
                    end
                    else if (!w.a && !w.b)
                    begin
                        // Both beams cleared before the crossing finished.
                        phase_copy[w.gate] = GP_IDLE;
                    end
                end
                default:
                begin
                    if (!w.a && !w.b)
                        phase_copy[w.gate] = GP_IDLE;
                end
            endcase
        end
        r.in_total  = in_tally;
        r.out_total = out_tally;
        return r;
    endfunction

    function automatic void push_sample(input logic [3:0] g, input logic a, input logic b,
                                        input logic [bgpc_pkg::TIME_W-1:0] ts);
        sensor_word_t w;
        w.gate = g;
        w.a    = a;
        w.b    = b;
        w.ts   = ts;
        sample_q.push_back(w);
    endfunction

    // Adds the next sample for gate g. Mostly this follows a real crossing:
    // the leading beam, then both beams, then the trailing beam, then clear.
    // Some samples are noise, and some crossings are abandoned halfway.
    task automatic queue_sensor_step(input logic [3:0] g);
        logic        a;
        logic        b;
        int unsigned roll;
        if ($urandom_range(0, 19) == 0)
            gen_time[g] = $urandom;
        else
            gen_time[g] = gen_time[g] + $urandom_range(1, 20000);
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
        begin
            a = 1'($urandom);
            b = 1'($urandom);
        end
        else
        begin
            unique case (gen_stage[g])
                0:
                begin
                    gen_inward[g] = 1'($urandom);
                    a             = gen_inward[g];
                    b             = !gen_inward[g];
                    gen_stage[g]  = 1;
                end
                1:
                begin
                    if (roll < 60)
                    begin
                        a            = 1'b1;
                        b            = 1'b1;
                        gen_stage[g] = 2;
                    end
                    else if (roll < 85)
                    begin
                        a = gen_inward[g];
                        b = !gen_inward[g];
                    end
                    else
                    begin
                        a            = 1'b0;
                        b            = 1'b0;
                        gen_stage[g] = 0;
                    end
                end
                default:
                begin
                    if (roll < 40)
                    begin
                        a = 1'b1;
                        b = 1'b1;
                    end
                    else if (roll < 70)
                    begin
                        a = !gen_inward[g];
                        b = gen_inward[g];
                    end
                    else
                    begin
                        a            = 1'b0;
                        b            = 1'b0;
                        gen_stage[g] = 0;
                    end
                end
            endcase
        end
        push_sample(g, a, b, gen_time[g]);
    endtask

    // Checked on the falling edge, after all clocked updates have settled.
    task automatic wait_until_drained();
        while (sample_q.size() != 0 || in_valid || expected_passages.size() != 0)
            @(negedge clk);
    endtask

    // Writes the gate count only once the block is idle. Every sample gives a
    // result, so an empty prediction queue means the pipeline is empty.
    task automatic set_active_gates(input logic [3:0] value);
        wait_until_drained();
        @(posedge clk);
        cfg_data     <= value;
        cfg_we       <= 1'b1;
        active_gates  = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Driver. The payload moves on only when the current word was taken or no
    // word is offered. The valid line is assigned once per edge.
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sensor_word_t w;
        int unsigned  burst_left;
        int unsigned  gap_left;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            gate         <= '0;
            sensor_a     <= 1'b0;
            sensor_b     <= 1'b0;
            timestamp_us <= '0;
            burst_left    = 1;
            gap_left      = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                w.gate = gate;
                w.a    = sensor_a;
                w.b    = sensor_b;
                w.ts   = timestamp_us;
                expected_passages.push_back(predict_passage(w));
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left  = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    w             = sample_q.pop_front();
                    gate         <= w.gate;
                    sensor_a     <= w.a;
                    sensor_b     <= w.b;
                    timestamp_us <= w.ts;
                    in_valid     <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end
                    else
                    begin
                        burst_left = burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. It checks each result word, then picks the stall value for the
    // next cycle. A new value of hold_seq starts the long hold, which this
    // process counts down by itself.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        passage_result_t want;
        passage_result_t got;
        int unsigned     hold_left;
        int unsigned     hold_seen;
        int unsigned     pat_cnt;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left  = 0;
            hold_seen  = 0;
            pat_cnt    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.passage_in  = passage_in;
                got.passage_out = passage_out;
                got.transit_us  = transit_us;
                got.in_total    = in_total;
                got.out_total   = out_total;
                got.ignored     = ignored;
                if (expected_passages.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result word with no sample pending", $realtime);
                end
                else
                begin
                    want = expected_passages.pop_front();
                    if (got !== want)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("%0t: expected in=%b out=%b transit=%0h tot=%0d/%0d ign=%b",
                                     $realtime, want.passage_in, want.passage_out,
                                     want.transit_us, want.in_total, want.out_total,
                                     want.ignored);
                            $display("%0t:      got in=%b out=%b transit=%0h tot=%0d/%0d ign=%b",
                                     $realtime, got.passage_in, got.passage_out,
                                     got.transit_us, got.in_total, got.out_total,
                                     got.ignored);
                        end
                    end
                end
            end

            pat_cnt = pat_cnt + 1;
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left  = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                unique case (stall_mode)
                    STALL_LIGHT:   out_stall <= ($urandom_range(0, 99) < 30);
                    STALL_PATTERN: out_stall <= ((pat_cnt % 7) < 3);
                    STALL_HEAVY:   out_stall <= ($urandom_range(0, 99) < 70);
                    default:       out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Watchdog. It ends the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        logic [3:0]  run_limit[5];
        int unsigned run_gap[5];
        stall_mode_t run_stall[5];
        int unsigned taken;
        int unsigned eff;
        logic [3:0]  g;

        run_limit = '{4'd12, 4'd1, 4'd7, 4'd15, 4'd0};
        run_limit[4] = 4'($urandom_range(2, 11));
        run_gap   = '{0, 4, 2, 10, 3};
        run_stall = '{STALL_NONE, STALL_LIGHT, STALL_PATTERN, STALL_HEAVY, STALL_LIGHT};
        for (int i = 0; i < 16; i++)
        begin
            gen_stage[i]  = 0;
            gen_inward[i] = 1'b0;
            gen_time[i]   = $urandom;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, with the gate count left at its reset value of two.
        // It covers an inward crossing, the hold until clear, and an outward
        // crossing whose transit wraps past zero.
        push_sample(4'd0, 1'b1, 1'b0, 32'd100);
        push_sample(4'd0, 1'b1, 1'b1, 32'd350);
        push_sample(4'd0, 1'b1, 1'b1, 32'd400);
        push_sample(4'd0, 1'b1, 1'b0, 32'd450);
        push_sample(4'd0, 1'b0, 1'b0, 32'd500);
        push_sample(4'd1, 1'b0, 1'b1, 32'hFFFF_FFF0);
        push_sample(4'd1, 1'b1, 1'b1, 32'h0000_0010);
        push_sample(4'd1, 1'b0, 1'b0, 32'h0000_0020);
        // Both beams at once from idle do nothing. An armed gate keeps its
        // start time while one beam is blocked, and clearing both abandons it.
        push_sample(4'd0, 1'b1, 1'b1, 32'd600);
        push_sample(4'd0, 1'b1, 1'b0, 32'd0);
        push_sample(4'd0, 1'b0, 1'b1, 32'd5);
        push_sample(4'd0, 1'b0, 1'b0, 32'd9);
        // Gates at or above the active count are ignored.
        push_sample(4'd2, 1'b1, 1'b0, 32'd1);
        push_sample(4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF);
        push_sample(4'd0, 1'b0, 1'b1, 32'hFFFF_FFFF);
        push_sample(4'd0, 1'b1, 1'b1, 32'd0);
        push_sample(4'd0, 1'b0, 1'b0, 32'd3);

        set_active_gates(4'd12);
        push_sample(4'd11, 1'b1, 1'b0, 32'd0);
        push_sample(4'd5, 1'b0, 1'b1, 32'd7);

        // Gates 5 and 11 are now above the limit and keep their armed phase.
        set_active_gates(4'd3);
        push_sample(4'd5, 1'b1, 1'b1, 32'd20);
        push_sample(4'd11, 1'b1, 1'b1, 32'd30);

        // A count above the number of gates is clipped, so gate 12 stays ignored.
        set_active_gates(4'd15);
        push_sample(4'd12, 1'b1, 1'b0, 32'd40);
        push_sample(4'd11, 1'b1, 1'b1, 32'hFFFF_FFFF);
        push_sample(4'd5, 1'b1, 1'b1, 32'd1000);

        // With zero active gates, every sample is ignored.
        set_active_gates(4'd0);
        push_sample(4'd0, 1'b1, 1'b0, 32'd50);

        // Random part. Each run has its own gate count and its own traffic
        // pattern. In the first run the receiver holds off for a long time
        // while the sender keeps offering words, so the block backs up.
        for (int r = 0; r < 5; r++)
        begin
            set_active_gates(run_limit[r]);
            gap_max    <= run_gap[r];
            stall_mode <= run_stall[r];
            if (r == 0)
                hold_seq <= hold_seq + 1;
            eff   = (active_gates > GATES) ? GATES : active_gates;
            taken = 0;
            while (taken < ITEMS_PER_RUN)
            begin
                if (eff != 0 && $urandom_range(0, 99) < 88)
                    g = 4'($urandom_range(0, eff - 1));
                else
                    g = 4'($urandom_range(0, 15));
                if (g < eff)
                    taken = taken + 1;
                queue_sensor_step(g);
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_passages.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bgpc_pkg.sv
sv/bgpc_gate_state.sv
sv/bidirectional_gate_passage_counter.sv
sim/tb_bidirectional_gate_passage_counter.sv
